### sv/tsbfs_pkg.sv
// ----------------------------------------------------------------------------
// tsbfs_pkg
// Shared types and codes for the three-source BFS meeting point block.
// ----------------------------------------------------------------------------
package tsbfs_pkg;

  localparam logic [1:0] CFG_VERTEX_COUNT = 2'd0;
  localparam logic [1:0] CFG_FIRST_POINT  = 2'd1;
  localparam logic [1:0] CFG_SECOND_POINT = 2'd2;
  localparam logic [1:0] CFG_THIRD_POINT  = 2'd3;

  localparam logic [1:0] SRC_FIRST  = 2'd0;
  localparam logic [1:0] SRC_SECOND = 2'd1;
  localparam logic [1:0] SRC_THIRD  = 2'd2;

  typedef struct packed {
    logic [9:0] edge_from;
    logic [9:0] edge_to;
    logic       last_edge;
  } in_t;

  typedef struct packed {
    logic [11:0] min_length;
    logic        found;
    logic        edge_error;
  } out_t;

  typedef enum logic [4:0] {
    OP_CLEAR,
    OP_IDLE,
    OP_CHECK,
    OP_HEAD_RD_A,
    OP_LINK_WR_A,
    OP_HEAD_RD_B,
    OP_LINK_WR_B,
    OP_SRC_INIT,
    OP_SRC_NEXT,
    OP_POP,
    OP_VERT_RD,
    OP_LIST_LATCH,
    OP_LINK_RD,
    OP_TARGET_RD,
    OP_TARGET_CHK,
    OP_SCAN_RD,
    OP_SCAN_CHK,
    OP_EMIT
  } op_e;

  typedef struct packed {
    op_e  op;
    logic accept;
  } cmd_t;

  typedef struct packed {
    logic edge_ok;
    logic is_last;
    logic src_ok;
    logic sel_last;
    logic q_empty;
    logic e_zero;
    logic n_zero;
    logic scan_last;
    logic clr_last;
  } status_t;

endpackage

### sv/tsbfs_ctrl.sv
// ----------------------------------------------------------------------------
// tsbfs_ctrl
// Sequencer for edge loading, the three searches, the scan and the clear.
// ----------------------------------------------------------------------------
module tsbfs_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  tsbfs_pkg::status_t status_i,
  output tsbfs_pkg::cmd_t    cmd_o
);

  typedef enum logic [17:0] {
    ST_CLEAR     = 18'h00001,
    ST_IDLE      = 18'h00002,
    ST_CHECK     = 18'h00004,
    ST_HEAD_RD_A = 18'h00008,
    ST_LINK_WR_A = 18'h00010,
    ST_HEAD_RD_B = 18'h00020,
    ST_LINK_WR_B = 18'h00040,
    ST_SRC_INIT  = 18'h00080,
    ST_SRC_NEXT  = 18'h00100,
    ST_POP       = 18'h00200,
    ST_VERT_RD   = 18'h00400,
    ST_LIST_LAT  = 18'h00800,
    ST_LINK_RD   = 18'h01000,
    ST_TGT_RD    = 18'h02000,
    ST_TGT_CHK   = 18'h04000,
    ST_SCAN_RD   = 18'h08000,
    ST_SCAN_CHK  = 18'h10000,
    ST_EMIT      = 18'h20000
  } state_e;

  state_e state_q, state_d;
  tsbfs_pkg::op_e op;

  always_comb begin
    state_d = state_q;
    op      = tsbfs_pkg::OP_IDLE;
    case (state_q)
      ST_CLEAR: begin
        op = tsbfs_pkg::OP_CLEAR;
        if (status_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        op = tsbfs_pkg::OP_IDLE;
        if (start) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        op = tsbfs_pkg::OP_CHECK;
        if (status_i.edge_ok) state_d = ST_HEAD_RD_A;
        else if (status_i.is_last) state_d = ST_SRC_INIT;
        else state_d = ST_IDLE;
      end
      ST_HEAD_RD_A: begin
        op = tsbfs_pkg::OP_HEAD_RD_A;
        state_d = ST_LINK_WR_A;
      end
      ST_LINK_WR_A: begin
        op = tsbfs_pkg::OP_LINK_WR_A;
        state_d = ST_HEAD_RD_B;
      end
      ST_HEAD_RD_B: begin
        op = tsbfs_pkg::OP_HEAD_RD_B;
        state_d = ST_LINK_WR_B;
      end
      ST_LINK_WR_B: begin
        op = tsbfs_pkg::OP_LINK_WR_B;
        state_d = status_i.is_last ? ST_SRC_INIT : ST_IDLE;
      end
      ST_SRC_INIT: begin
        op = tsbfs_pkg::OP_SRC_INIT;
        state_d = status_i.src_ok ? ST_POP : ST_SRC_NEXT;
      end
      ST_SRC_NEXT: begin
        op = tsbfs_pkg::OP_SRC_NEXT;
        if (!status_i.sel_last) state_d = ST_SRC_INIT;
        else if (status_i.n_zero) state_d = ST_EMIT;
        else state_d = ST_SCAN_RD;
      end
      ST_POP: begin
        op = tsbfs_pkg::OP_POP;
        state_d = status_i.q_empty ? ST_SRC_NEXT : ST_VERT_RD;
      end
      ST_VERT_RD: begin
        op = tsbfs_pkg::OP_VERT_RD;
        state_d = ST_LIST_LAT;
      end
      ST_LIST_LAT: begin
        op = tsbfs_pkg::OP_LIST_LATCH;
        state_d = ST_LINK_RD;
      end
      ST_LINK_RD: begin
        op = tsbfs_pkg::OP_LINK_RD;
        state_d = status_i.e_zero ? ST_POP : ST_TGT_RD;
      end
      ST_TGT_RD: begin
        op = tsbfs_pkg::OP_TARGET_RD;
        state_d = ST_TGT_CHK;
      end
      ST_TGT_CHK: begin
        op = tsbfs_pkg::OP_TARGET_CHK;
        state_d = ST_LINK_RD;
      end
      ST_SCAN_RD: begin
        op = tsbfs_pkg::OP_SCAN_RD;
        state_d = ST_SCAN_CHK;
      end
      ST_SCAN_CHK: begin
        op = tsbfs_pkg::OP_SCAN_CHK;
        state_d = status_i.scan_last ? ST_EMIT : ST_SCAN_RD;
      end
      ST_EMIT: begin
        op = tsbfs_pkg::OP_EMIT;
        state_d = ST_CLEAR;
      end
      default: begin
        op = tsbfs_pkg::OP_IDLE;
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy          = (state_q != ST_IDLE);
  assign cmd_o.op      = op;
  assign cmd_o.accept  = start && (state_q == ST_IDLE);

endmodule

### sv/tsbfs_datapath.sv
// ----------------------------------------------------------------------------
// tsbfs_datapath
// Configuration, adjacency, distance and queue memories and search arithmetic.
// ----------------------------------------------------------------------------
module tsbfs_datapath #(
  parameter int unsigned MAX_VERTICES = 1024,
  parameter int unsigned MAX_EDGES    = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [10:0]        cfg_data_i,
  input  tsbfs_pkg::in_t     item_i,
  input  tsbfs_pkg::cmd_t    cmd_i,
  output tsbfs_pkg::status_t status_o,
  output logic               done_o,
  output tsbfs_pkg::out_t    result_o
);

  localparam int unsigned VW    = $clog2(MAX_VERTICES);
  localparam int unsigned CW    = (VW + 1 > 11) ? VW + 1 : 11;
  localparam int unsigned DW    = VW + 1;
  localparam int unsigned SW    = (DW + 2 > 12) ? DW + 2 : 12;
  localparam int unsigned SLOTS = 2 * MAX_EDGES;
  localparam int unsigned LW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned HW    = $clog2(SLOTS + 1);
  localparam logic [DW-1:0] UNR = '1;

  logic [10:0] vc_q;
  logic [9:0]  p1_q, p2_q, p3_q;
  logic [9:0]  a_q, b_q;
  logic        last_q;
  logic [HW-1:0] cnt_q, e_q;
  logic        err_q, found_q;
  logic [1:0]  sel_q;
  logic [VW:0] qh_q, qt_q;
  logic [CW-1:0] i_q;
  logic [VW-1:0] clr_q, w_q;
  logic [DW-1:0] dv_q;
  logic [SW-1:0] best_q;

  logic [HW-1:0] head_rd_q, nxt_rd_q;
  logic [VW-1:0] tgt_rd_q, q_rd_q;
  logic [DW-1:0] dist_rd_q [3];

  logic [CW-1:0] n, a_ext, b_ext, src_ext, w_ext, i_p1;
  logic [VW-1:0] a_idx, b_idx, src_idx;
  logic [9:0]    src10;
  logic          room, edge_ok, src_ok, take, all_reached;
  logic [HW-1:0] cnt_p1, e_m1;
  logic [DW-1:0] ds, dv_p1;
  logic [SW-1:0] sum;
  tsbfs_pkg::op_e op;

  assign op      = cmd_i.op;
  assign n       = (CW'(vc_q) > CW'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : CW'(vc_q);
  assign a_ext   = CW'(a_q);
  assign b_ext   = CW'(b_q);
  assign a_idx   = a_ext[VW-1:0];
  assign b_idx   = b_ext[VW-1:0];
  assign room    = ((HW+1)'(cnt_q) + (HW+1)'(2)) <= (HW+1)'(SLOTS);
  assign edge_ok = (a_ext < n) && (b_ext < n) && room;
  assign cnt_p1  = cnt_q + HW'(1);
  assign e_m1    = e_q - HW'(1);
  assign w_ext   = CW'(w_q);
  assign i_p1    = i_q + CW'(1);
  assign dv_p1   = dv_q + DW'(1);

  always_comb begin
    case (sel_q)
      tsbfs_pkg::SRC_FIRST:  src10 = p1_q;
      tsbfs_pkg::SRC_SECOND: src10 = p2_q;
      default:               src10 = p3_q;
    endcase
  end
  assign src_ext = CW'(src10);
  assign src_idx = src_ext[VW-1:0];
  assign src_ok  = src_ext < n;

  always_comb begin
    case (sel_q)
      tsbfs_pkg::SRC_FIRST:  ds = dist_rd_q[0];
      tsbfs_pkg::SRC_SECOND: ds = dist_rd_q[1];
      default:               ds = dist_rd_q[2];
    endcase
  end

  assign take = (op == tsbfs_pkg::OP_TARGET_CHK) && (w_ext < n) && (ds == UNR);
  assign all_reached = (dist_rd_q[0] != UNR) && (dist_rd_q[1] != UNR) &&
                       (dist_rd_q[2] != UNR);
  assign sum = SW'(dist_rd_q[0]) + SW'(dist_rd_q[1]) + SW'(dist_rd_q[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 11'd1;
      p1_q <= '0;
      p2_q <= '0;
      p3_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tsbfs_pkg::CFG_VERTEX_COUNT: vc_q <= cfg_data_i;
        tsbfs_pkg::CFG_FIRST_POINT:  p1_q <= cfg_data_i[9:0];
        tsbfs_pkg::CFG_SECOND_POINT: p2_q <= cfg_data_i[9:0];
        tsbfs_pkg::CFG_THIRD_POINT:  p3_q <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      err_q   <= 1'b0;
      found_q <= 1'b0;
      sel_q   <= tsbfs_pkg::SRC_FIRST;
      qh_q    <= '0;
      qt_q    <= '0;
      i_q     <= '0;
      clr_q   <= '0;
    end else begin
      case (op)
        tsbfs_pkg::OP_CLEAR: clr_q <= clr_q + VW'(1);
        tsbfs_pkg::OP_CHECK: begin
          if (!edge_ok) err_q <= 1'b1;
          sel_q <= tsbfs_pkg::SRC_FIRST;
        end
        tsbfs_pkg::OP_LINK_WR_A, tsbfs_pkg::OP_LINK_WR_B: cnt_q <= cnt_p1;
        tsbfs_pkg::OP_SRC_INIT: begin
          if (src_ok) begin
            qh_q <= '0;
            qt_q <= (VW+1)'(1);
          end
        end
        tsbfs_pkg::OP_SRC_NEXT: begin
          if (sel_q == tsbfs_pkg::SRC_THIRD) begin
            i_q     <= '0;
            found_q <= 1'b0;
          end else begin
            sel_q <= sel_q + 2'd1;
          end
        end
        tsbfs_pkg::OP_POP: if (qh_q != qt_q) qh_q <= qh_q + (VW+1)'(1);
        tsbfs_pkg::OP_TARGET_CHK: if (take) qt_q <= qt_q + (VW+1)'(1);
        tsbfs_pkg::OP_SCAN_CHK: begin
          if (all_reached) found_q <= 1'b1;
          i_q <= i_p1;
        end
        tsbfs_pkg::OP_EMIT: begin
          cnt_q <= '0;
          err_q <= 1'b0;
          clr_q <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      a_q    <= item_i.edge_from;
      b_q    <= item_i.edge_to;
      last_q <= item_i.last_edge;
    end
    case (op)
      tsbfs_pkg::OP_SRC_NEXT: if (sel_q == tsbfs_pkg::SRC_THIRD) best_q <= '0;
      tsbfs_pkg::OP_LIST_LATCH: begin
        e_q  <= head_rd_q;
        dv_q <= ds;
      end
      tsbfs_pkg::OP_TARGET_RD: begin
        w_q <= tgt_rd_q;
        e_q <= nxt_rd_q;
      end
      tsbfs_pkg::OP_SCAN_CHK: begin
        if (all_reached && (!found_q || sum < best_q)) best_q <= sum;
      end
      default: ;
    endcase
  end

  // List heads.
  logic [HW-1:0] head_mem [MAX_VERTICES];
  logic          head_we;
  logic [VW-1:0] head_wa, head_ra;
  logic [HW-1:0] head_wd;

  always_comb begin
    head_we = 1'b0;
    head_wa = clr_q;
    head_wd = '0;
    head_ra = q_rd_q;
    case (op)
      tsbfs_pkg::OP_CLEAR: head_we = 1'b1;
      tsbfs_pkg::OP_HEAD_RD_A: head_ra = a_idx;
      tsbfs_pkg::OP_HEAD_RD_B: head_ra = b_idx;
      tsbfs_pkg::OP_LINK_WR_A: begin
        head_we = 1'b1;
        head_wa = a_idx;
        head_wd = cnt_p1;
      end
      tsbfs_pkg::OP_LINK_WR_B: begin
        head_we = 1'b1;
        head_wa = b_idx;
        head_wd = cnt_p1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    head_rd_q <= head_mem[head_ra];
  end

  // Link target and next memories.
  logic [VW-1:0] tgt_mem [SLOTS];
  logic [HW-1:0] nxt_mem [SLOTS];
  logic          link_we;
  logic [VW-1:0] link_wt;

  assign link_we = (op == tsbfs_pkg::OP_LINK_WR_A) || (op == tsbfs_pkg::OP_LINK_WR_B);
  assign link_wt = (op == tsbfs_pkg::OP_LINK_WR_A) ? b_idx : a_idx;

  always_ff @(posedge clk_i) begin
    if (link_we) begin
      tgt_mem[cnt_q[LW-1:0]] <= link_wt;
      nxt_mem[cnt_q[LW-1:0]] <= head_rd_q;
    end
    tgt_rd_q <= tgt_mem[e_m1[LW-1:0]];
    nxt_rd_q <= nxt_mem[e_m1[LW-1:0]];
  end

  // Search queue.
  logic [VW-1:0] q_mem [MAX_VERTICES];
  logic          q_we;
  logic [VW-1:0] q_wa, q_wd;

  assign q_we = ((op == tsbfs_pkg::OP_SRC_INIT) && src_ok) || take;
  assign q_wa = (op == tsbfs_pkg::OP_SRC_INIT) ? '0 : qt_q[VW-1:0];
  assign q_wd = (op == tsbfs_pkg::OP_SRC_INIT) ? src_idx : w_q;

  always_ff @(posedge clk_i) begin
    if (q_we) q_mem[q_wa] <= q_wd;
    q_rd_q <= q_mem[qh_q[VW-1:0]];
  end

  // Distance memories, one per search.
  logic [VW-1:0] dist_wa, dist_ra;
  logic [DW-1:0] dist_wd;

  always_comb begin
    dist_wa = w_q;
    dist_wd = dv_p1;
    dist_ra = i_q[VW-1:0];
    case (op)
      tsbfs_pkg::OP_CLEAR: begin
        dist_wa = clr_q;
        dist_wd = UNR;
      end
      tsbfs_pkg::OP_SRC_INIT: begin
        dist_wa = src_idx;
        dist_wd = '0;
      end
      tsbfs_pkg::OP_VERT_RD: dist_ra = q_rd_q;
      tsbfs_pkg::OP_TARGET_RD: dist_ra = tgt_rd_q;
      default: ;
    endcase
  end

  for (genvar k = 0; k < 3; k++) begin : g_dist
    logic [DW-1:0] mem [MAX_VERTICES];
    logic          we;

    assign we = (op == tsbfs_pkg::OP_CLEAR) ||
                ((sel_q == 2'(k)) &&
                 (((op == tsbfs_pkg::OP_SRC_INIT) && src_ok) || take));

    always_ff @(posedge clk_i) begin
      if (we) mem[dist_wa] <= dist_wd;
      dist_rd_q[k] <= mem[dist_ra];
    end
  end

  assign status_o.edge_ok   = edge_ok;
  assign status_o.is_last   = last_q;
  assign status_o.src_ok    = src_ok;
  assign status_o.sel_last  = (sel_q == tsbfs_pkg::SRC_THIRD);
  assign status_o.q_empty   = (qh_q == qt_q);
  assign status_o.e_zero    = (e_q == '0);
  assign status_o.n_zero    = (n == '0);
  assign status_o.scan_last = (i_p1 == n);
  assign status_o.clr_last  = (clr_q == VW'(MAX_VERTICES - 1));

  assign done_o              = (op == tsbfs_pkg::OP_EMIT);
  assign result_o.min_length = best_q[11:0];
  assign result_o.found      = found_q;
  assign result_o.edge_error = err_q;

endmodule

### sv/three_source_bfs_meeting_point.sv
// ----------------------------------------------------------------------------
// three_source_bfs_meeting_point
// Loads an undirected graph edge by edge, then finds the least sum of hop
// distances from three start vertices over commonly reachable vertices.
//
//   channel   ports                              transfer when
//   edge in   start, item_i, busy                start && !busy
//   result    done_o, result_o                   done_o (one cycle)
//   config    cfg_we_i, cfg_idx_i, cfg_data_i    cfg_we_i
//
// After its transfer an edge holds busy high through the check, both head
// reads and both link writes, a dropped edge through the check alone; no
// new edge is taken until busy falls. On the edge marked last the three
// searches pop each reached vertex, read it, latch its list, then read each
// link walked and read and check its target; the scan reads and checks each
// vertex. After reset and after each result a clearing pass over all
// MAX_VERTICES entries runs with busy high. The result cannot be stalled.
module three_source_bfs_meeting_point #(
  parameter int unsigned MAX_VERTICES = 1024,
  parameter int unsigned MAX_EDGES    = 4096
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_idx_i,
  input  logic [10:0]     cfg_data_i,
  input  logic            start,
  output logic            busy,
  input  tsbfs_pkg::in_t  item_i,
  output logic            done_o,
  output tsbfs_pkg::out_t result_o
);

  tsbfs_pkg::cmd_t    cmd;
  tsbfs_pkg::status_t status;

  tsbfs_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .status_i (status),
    .cmd_o    (cmd)
  );

  tsbfs_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_EDGES    (MAX_EDGES)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .item_i     (item_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .done_o     (done_o),
    .result_o   (result_o)
  );

endmodule
